/* rtl/dsrq_pkg.sv */
`timescale 1ns / 1ps
package dsrq_pkg;
  localparam int LogSize = 10;
  localparam int ValueWidth = 32;
  localparam int Capacity = 1 << LogSize;
  localparam int HalfCap = Capacity >> 1;
  localparam int TabDepth = LogSize * HalfCap;
  localparam int IdxW = LogSize;
  localparam int CntW = LogSize + 1;
  localparam int TabAw = $clog2(TabDepth);
  localparam int LvlW = $clog2(LogSize + 1);

  localparam logic [2:0] MODE_SUM = 3'd0;
  localparam logic [2:0] MODE_MIN = 3'd1;
  localparam logic [2:0] MODE_MAX = 3'd2;
  localparam logic [2:0] MODE_XOR = 3'd3;
  localparam logic [2:0] MODE_AND = 3'd4;
  localparam logic [2:0] MODE_OR  = 3'd5;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_LOADED = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [31:0] element_value;
    logic        is_last;
    logic [9:0]  query_left;
    logic [10:0] query_right_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_QADDR, S_QWAIT, S_QMERGE,
    S_BSEG, S_BRD, S_BWAIT, S_BWR, S_OUT
  } state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic take_item;    // latch input item
    logic do_load;      // store element, bump count
    logic q_addr;       // present query read addresses
    logic q_merge;      // form query result
    logic q_reject;     // reject result
    logic load_result;  // load status result
    logic b_init;       // start build walk
    logic b_seg;        // set up current segment
    logic b_rd;         // issue element read
    logic b_wr;         // accumulate and write table entry
    logic b_done;       // mark built
    logic out_pop;      // result taken
  } ctrl_t;

  // Datapath -> controller status
  typedef struct packed {
    logic is_query;
    logic is_last;
    logic query_ok;
    logic seg_skip;     // segment midpoint past count
    logic seg_end;      // current side finished
    logic side_right;
    logic last_seg;     // last segment of last level
    logic res_valid;
  } stat_t;

  function automatic logic [ValueWidth-1:0] merge_f(
      input logic [2:0] mode, input logic [ValueWidth-1:0] a,
      input logic [ValueWidth-1:0] b);
    logic [ValueWidth-1:0] r;
    unique case (mode)
      MODE_MIN: r = (a < b) ? a : b;
      MODE_MAX: r = (a > b) ? a : b;
      MODE_XOR: r = a ^ b;
      MODE_AND: r = a & b;
      MODE_OR:  r = a | b;
      default:  r = a + b;
    endcase
    return r;
  endfunction
endpackage

/* rtl/disjoint_sparse_range_query.sv */
`timescale 1ns / 1ps
// Channel | Direction | Payload          | Handshake
// in_     | input     | in_item_t        | in_valid / in_ready
// out_    | output    | out_item_t       | out_valid / out_ready
// cfg_    | input     | merge_mode[2:0]  | cfg_valid / cfg_ready
// One item in flight at a time. A query makes two table reads through
// registered RAM ports, then one merge.
// A load flagged last also runs the build before it answers: a setup step per
// tree segment, then one element read and one table write per entry,
// N*logN entries at most.
// Reset is synchronous, active low; it clears count, built flag and mode.
// A stalled output holds the block; nothing new is taken until transfer.
module disjoint_sparse_range_query (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dsrq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dsrq_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_merge_mode
);
  import dsrq_pkg::*;

  logic [2:0] mode_r;
  ctrl_t cmd;
  stat_t st;

  // config is always writable
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= MODE_SUM;
    else if (cfg_valid) mode_r <= cfg_merge_mode;
  end

  dsrq_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_ready, .st, .cmd);

  dsrq_dp u_dp (
    .clk, .rst_n, .in_item(in_data), .mode(mode_r), .cmd, .st, .out_item(out_data));

  assign out_valid = st.res_valid;
endmodule

/* rtl/dsrq_ram.sv */
`timescale 1ns / 1ps
module dsrq_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/dsrq_ctrl.sv */
`timescale 1ns / 1ps
module dsrq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            out_ready,
  input  dsrq_pkg::stat_t st,
  output dsrq_pkg::ctrl_t cmd
);
  import dsrq_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (st.is_query) begin
          if (st.query_ok) begin
            cmd.q_addr = 1'b1;
            state_nxt = S_QWAIT;
          end else begin
            cmd.q_reject = 1'b1;
            state_nxt = S_OUT;
          end
        end else begin
          cmd.do_load = 1'b1;
          cmd.load_result = 1'b1;
          if (st.is_last) begin
            cmd.b_init = 1'b1;
            state_nxt = S_BSEG;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_QADDR: state_nxt = S_QWAIT;
      S_QWAIT: state_nxt = S_QMERGE;
      S_QMERGE: begin
        cmd.q_merge = 1'b1;
        state_nxt = S_OUT;
      end
      S_BSEG: begin
        cmd.b_seg = 1'b1;
        if (st.seg_skip) begin
          if (st.last_seg) begin
            cmd.b_done = 1'b1;
            state_nxt = S_OUT;
          end
        end else begin
          state_nxt = S_BRD;
        end
      end
      S_BRD: begin
        cmd.b_rd = 1'b1;
        state_nxt = S_BWAIT;
      end
      S_BWAIT: state_nxt = S_BWR;
      S_BWR: begin
        cmd.b_wr = 1'b1;
        if (st.seg_end && st.side_right) begin
          if (st.last_seg) begin
            cmd.b_done = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_BSEG;
          end
        end else begin
          state_nxt = S_BRD;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.out_pop = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

/* rtl/dsrq_dp.sv */
`timescale 1ns / 1ps
module dsrq_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  dsrq_pkg::in_item_t  in_item,
  input  logic [2:0]          mode,
  input  dsrq_pkg::ctrl_t     cmd,
  output dsrq_pkg::stat_t     st,
  output dsrq_pkg::out_item_t out_item
);
  import dsrq_pkg::*;

  in_item_t item_r;
  logic [CntW-1:0] count_r, count_nxt;
  logic built_r;
  logic res_valid_r;
  out_item_t res_r;

  // build walk
  logic [LvlW-1:0] lvl_r;      // level d
  logic [IdxW-1:0] blk_r;      // block p within level
  logic [IdxW-1:0] step_r;     // offset i
  logic side_r;                // 0 left suffix, 1 right prefix
  logic [ValueWidth-1:0] acc_r;
  logic first_r;

  logic [LvlW-1:0] h;
  logic [CntW-1:0] half, mid;
  logic [TabAw-1:0] base;

  // element RAM
  logic e_we;
  logic [IdxW-1:0] e_waddr, e_raddr;
  logic [ValueWidth-1:0] e_rdata;
  // tables
  logic l_we, r_we;
  logic [TabAw-1:0] l_addr_w, r_addr_w, l_raddr, r_raddr;
  logic [ValueWidth-1:0] l_rdata, r_rdata, wval;
  logic single_r;

  dsrq_ram #(.Width(ValueWidth), .Depth(Capacity)) u_elem (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(item_r.element_value[ValueWidth-1:0]),
    .raddr(e_raddr), .rdata(e_rdata));
  dsrq_ram #(.Width(ValueWidth), .Depth(TabDepth)) u_left (
    .clk, .we(l_we), .waddr(l_addr_w), .wdata(wval), .raddr(l_raddr), .rdata(l_rdata));
  dsrq_ram #(.Width(ValueWidth), .Depth(TabDepth)) u_right (
    .clk, .we(r_we), .waddr(r_addr_w), .wdata(wval), .raddr(r_raddr), .rdata(r_rdata));

  // current segment geometry
  assign h    = LvlW'(LogSize - 1) - lvl_r;
  assign half = CntW'(1) << h;
  assign mid  = (CntW'(blk_r) << (h + 1'b1)) + half;
  assign base = TabAw'(lvl_r) * TabAw'(HalfCap) + (TabAw'(blk_r) << h);

  // query decode
  logic [IdxW-1:0] ql, qr, qx, qmid;
  logic [LvlW-1:0] qh, qd;
  logic [IdxW-1:0] qp;
  logic [TabAw-1:0] qbase;
  logic [CntW-1:0] qrend;
  assign qrend = item_r.query_right_end;
  assign ql = item_r.query_left;
  assign qr = IdxW'(qrend - 1'b1);
  assign qx = ql ^ qr;
  always_comb begin
    qh = '0;
    for (int k = 0; k < IdxW; k++) if (qx[k]) qh = LvlW'(k);
  end
  assign qd = LvlW'(LogSize - 1) - qh;
  assign qp = ql >> (qh + 1'b1);
  assign qmid = (qp << (qh + 1'b1)) + (IdxW'(1) << qh);
  assign qbase = TabAw'(qd) * TabAw'(HalfCap) + (TabAw'(qp) << qh);

  logic [IdxW-1:0] rd_idx;
  logic [CntW-1:0] next_pos;
  always_comb begin
    rd_idx = side_r ? IdxW'(mid + CntW'(step_r)) : IdxW'(mid - 1'b1 - CntW'(step_r));
    e_we = cmd.do_load && (count_nxt != '0) && (count_r < CntW'(Capacity) || built_r);
    e_waddr = built_r ? '0 : IdxW'(count_r);
    // a query holds its element address until the merge
    e_raddr = (item_r.operation == OP_QUERY) ? ql : rd_idx;
    l_raddr = qbase + TabAw'(qmid - 1'b1 - ql);
    r_raddr = qbase + TabAw'(qr - qmid);
    wval = first_r ? e_rdata
         : (side_r ? merge_f(mode, acc_r, e_rdata) : merge_f(mode, e_rdata, acc_r));
    l_we = cmd.b_wr && !side_r;
    r_we = cmd.b_wr && side_r;
    l_addr_w = base + TabAw'(step_r);
    r_addr_w = base + TabAw'(step_r);
    next_pos = mid + CntW'(step_r) + 1'b1;
  end

  assign count_nxt = built_r ? CntW'(1) : count_r + 1'b1;

  logic step_last;
  assign step_last = (CntW'(step_r) + 1'b1 == half) ||
                     (side_r && next_pos >= count_r);
  logic last_blk;
  assign last_blk = (CntW'(blk_r) + 1'b1 == (CntW'(1) << lvl_r));

  always_comb begin
    st.is_query   = item_r.operation == OP_QUERY;
    st.is_last    = item_r.is_last;
    st.query_ok   = built_r && (CntW'(ql) < qrend) && (qrend <= count_r);
    st.seg_skip   = mid >= count_r;
    st.seg_end    = step_last;
    st.side_right = side_r;
    st.last_seg   = last_blk && (lvl_r == LvlW'(LogSize - 1));
    st.res_valid  = res_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      built_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (cmd.do_load) begin
        if (built_r) begin
          built_r <= 1'b0;
          count_r <= CntW'(1);
        end else if (count_r < CntW'(Capacity)) begin
          count_r <= count_r + 1'b1;
        end
      end
      if (cmd.b_done) built_r <= 1'b1;
      // a load that starts the build answers once the build is done
      if ((cmd.load_result && !cmd.b_init) || cmd.q_reject || cmd.q_merge || cmd.b_done)
        res_valid_r <= 1'b1;
      if (cmd.out_pop) res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) item_r <= in_item;
    if (cmd.q_addr) single_r <= (ql == qr);
    if (cmd.load_result) begin
      res_r.result_value <= '0;
      res_r.status <= (built_r || count_r < CntW'(Capacity)) ? ST_LOADED : ST_REJECT;
    end
    if (cmd.q_reject) begin
      res_r.result_value <= '0;
      res_r.status <= ST_REJECT;
    end
    if (cmd.q_merge) begin
      res_r.result_value <= 32'(single_r ? e_rdata : merge_f(mode, l_rdata, r_rdata));
      res_r.status <= ST_OK;
    end
    if (cmd.b_init) begin
      lvl_r <= '0;
      blk_r <= '0;
    end
    if (cmd.b_seg) begin
      side_r <= 1'b0;
      step_r <= '0;
      first_r <= 1'b1;
      if (mid >= count_r) begin
        if (last_blk) begin
          lvl_r <= lvl_r + 1'b1;
          blk_r <= '0;
        end else begin
          blk_r <= blk_r + 1'b1;
        end
      end
    end
    if (cmd.b_wr) begin
      acc_r <= wval;
      if (step_last) begin
        step_r <= '0;
        first_r <= 1'b1;
        if (side_r) begin
          if (last_blk) begin
            lvl_r <= lvl_r + 1'b1;
            blk_r <= '0;
          end else begin
            blk_r <= blk_r + 1'b1;
          end
        end
        side_r <= ~side_r;
      end else begin
        step_r <= step_r + 1'b1;
        first_r <= 1'b0;
      end
    end
  end

  assign out_item = res_r;
endmodule
